// ===== design/btb_pkg.sv =====
// btb_pkg: shared types, widths and constants for the bilinear texel tint blend unit.
// No dependencies.

package btb_pkg;

   // Fixed-point and geometry constants
   localparam int FRAC_BITS      = 14;
   localparam int MAX_SOURCE_DIM = 2048;
   localparam int COORD_WIDTH    = 26;
   localparam int DIM_WIDTH      = 12;
   localparam int PIXEL_WIDTH    = 32;
   localparam int CHAN_WIDTH     = 8;
   localparam int NUM_CHANS      = 4;
   localparam int NUM_COLORS     = 3;
   localparam int ALPHA_CHAN     = 3;

   // Derived widths
   localparam int LIM_WIDTH   = DIM_WIDTH + FRAC_BITS;
   localparam int CMP_WIDTH   = (LIM_WIDTH > COORD_WIDTH) ? LIM_WIDTH : COORD_WIDTH;
   localparam int SUM_WIDTH   = CHAN_WIDTH + FRAC_BITS + 1;
   localparam int PROD_WIDTH  = 2 * CHAN_WIDTH;
   localparam int TRIPLE_WIDTH = 3 * CHAN_WIDTH;
   localparam int BLEND_WIDTH = PROD_WIDTH + 1;

   localparam logic [FRAC_BITS-1:0]  FRAC_MASK = {FRAC_BITS{1'b1}};
   localparam logic [CHAN_WIDTH-1:0] CHAN_MAX  = {CHAN_WIDTH{1'b1}};

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 4;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TINT_COLOR    = 4'd0,
      CSR_ALPHA_OR_WORD = 4'd1,
      CSR_SOURCE_HEIGHT = 4'd2,
      CSR_SOURCE_WIDTH  = 4'd3
   } csr_index_type;

   // Configuration reset values
   localparam logic [PIXEL_WIDTH-1:0] TINT_COLOR_RESET    = {PIXEL_WIDTH{1'b1}};
   localparam logic [PIXEL_WIDTH-1:0] ALPHA_OR_WORD_RESET = '0;
   localparam logic [DIM_WIDTH-1:0]   SOURCE_DIM_RESET    = DIM_WIDTH'(MAX_SOURCE_DIM);

   // Pixel viewed as four byte channels, index 3 is alpha
   typedef logic [NUM_CHANS-1:0][CHAN_WIDTH-1:0]  argb_type;
   typedef logic [NUM_COLORS-1:0][PROD_WIDTH-1:0] color_prod_type;

   // Clamp a dimension register to 1..MAX_SOURCE_DIM
   function automatic logic [DIM_WIDTH:0] clamp_dim(input logic [DIM_WIDTH-1:0] d);
      logic [DIM_WIDTH:0] r;
      r = {1'b0, d};
      if (d == '0) begin
         r = (DIM_WIDTH+1)'(1);
      end else if (r > (DIM_WIDTH+1)'(MAX_SOURCE_DIM)) begin
         r = (DIM_WIDTH+1)'(MAX_SOURCE_DIM);
      end
      return r;
   endfunction

endpackage

// ===== design/bilinear_texel_tint_blend_unit.sv =====
// bilinear_texel_tint_blend_unit: per-pixel bilinear sample, tint and blend over destination.
// Depends on btb_pkg.

// Takes one pixel beat per clock while the result side does not stall and returns one
// result beat per input, in order. The work runs through five register stages (bounds
// test, horizontal lerp, vertical lerp, tint and coverage, blend); the last stage is the
// output register. The whole pipe advances together whenever the output register is
// empty or being taken, so req_ready follows rsp_ready. Configuration writes are taken
// in every cycle (csr_ready is always high) and must only happen while no pixel is in
// flight.
module bilinear_texel_tint_blend_unit
   import btb_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [PIXEL_WIDTH-1:0]            csr_wdata,
   // pixel input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_WIDTH-1:0]     req_row_coord,
   input  logic signed [COORD_WIDTH-1:0]     req_col_coord,
   input  logic [PIXEL_WIDTH-1:0]            req_texel_top_left,
   input  logic [PIXEL_WIDTH-1:0]            req_texel_top_right,
   input  logic [PIXEL_WIDTH-1:0]            req_texel_bottom_right,
   input  logic [PIXEL_WIDTH-1:0]            req_texel_bottom_left,
   input  logic [PIXEL_WIDTH-1:0]            req_dest_pixel,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [PIXEL_WIDTH-1:0]            rsp_pixel_out,
   output logic                              rsp_written
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [PIXEL_WIDTH-1:0] tint_ff, tint_in;
   logic [PIXEL_WIDTH-1:0] or_word_ff, or_word_in;
   logic [DIM_WIDTH-1:0]   height_ff, height_in;
   logic [DIM_WIDTH-1:0]   width_ff, width_in;

   assign csr_ready = 1'b1;

   always_comb begin
      tint_in    = tint_ff;
      or_word_in = or_word_ff;
      height_in  = height_ff;
      width_in   = width_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TINT_COLOR:    tint_in    = csr_wdata;
            CSR_ALPHA_OR_WORD: or_word_in = csr_wdata;
            CSR_SOURCE_HEIGHT: height_in  = csr_wdata[DIM_WIDTH-1:0];
            CSR_SOURCE_WIDTH:  width_in   = csr_wdata[DIM_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff    <= TINT_COLOR_RESET;
         or_word_ff <= ALPHA_OR_WORD_RESET;
         height_ff  <= SOURCE_DIM_RESET;
         width_ff   <= SOURCE_DIM_RESET;
      end else begin
         tint_ff    <= tint_in;
         or_word_ff <= or_word_in;
         height_ff  <= height_in;
         width_ff   <= width_in;
      end
   end

   argb_type tint_chan;
   assign tint_chan = tint_ff;

   // ---------------------------------------------------------------
   // Pipeline advance: everything moves when the output slot frees up
   // ---------------------------------------------------------------
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   assign advance   = !s5_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: bounds test, split off fractions
   // ---------------------------------------------------------------
   logic [DIM_WIDTH:0]    height_c, width_c;
   logic [LIM_WIDTH-1:0]  row_lim, col_lim;
   logic                  row_pos, col_pos;
   logic                  s1_inb_in;

   always_comb begin
      height_c  = clamp_dim(height_ff);
      width_c   = clamp_dim(width_ff);
      row_lim   = LIM_WIDTH'(height_c - (DIM_WIDTH+1)'(1)) << FRAC_BITS;
      col_lim   = LIM_WIDTH'(width_c - (DIM_WIDTH+1)'(1)) << FRAC_BITS;
      row_pos   = !req_row_coord[COORD_WIDTH-1] && (req_row_coord != '0);
      col_pos   = !req_col_coord[COORD_WIDTH-1] && (req_col_coord != '0);
      s1_inb_in = row_pos && col_pos
                  && (CMP_WIDTH'(unsigned'(req_row_coord)) < CMP_WIDTH'(row_lim))
                  && (CMP_WIDTH'(unsigned'(req_col_coord)) < CMP_WIDTH'(col_lim));
   end

   logic                 s1_inb_ff;
   logic [FRAC_BITS-1:0] s1_fx_ff, s1_fy_ff;
   argb_type             s1_tl_ff, s1_tr_ff, s1_br_ff, s1_bl_ff;
   logic [PIXEL_WIDTH-1:0] s1_dest_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inb_ff  <= s1_inb_in;
         s1_fx_ff   <= req_col_coord[FRAC_BITS-1:0];
         s1_fy_ff   <= req_row_coord[FRAC_BITS-1:0];
         s1_tl_ff   <= req_texel_top_left;
         s1_tr_ff   <= req_texel_top_right;
         s1_br_ff   <= req_texel_bottom_right;
         s1_bl_ff   <= req_texel_bottom_left;
         s1_dest_ff <= req_dest_pixel;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: horizontal lerp of top and bottom rows, all channels
   // ---------------------------------------------------------------
   argb_type s2_top_in, s2_bot_in;
   logic [FRAC_BITS-1:0] ix;
   logic [SUM_WIDTH-1:0] top_sum, bot_sum;

   always_comb begin
      ix = FRAC_MASK - s1_fx_ff;
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         top_sum = SUM_WIDTH'(s1_tl_ff[ch]) * SUM_WIDTH'(ix)
                 + SUM_WIDTH'(s1_tr_ff[ch]) * SUM_WIDTH'(s1_fx_ff);
         bot_sum = SUM_WIDTH'(s1_bl_ff[ch]) * SUM_WIDTH'(ix)
                 + SUM_WIDTH'(s1_br_ff[ch]) * SUM_WIDTH'(s1_fx_ff);
         s2_top_in[ch] = top_sum[FRAC_BITS +: CHAN_WIDTH];
         s2_bot_in[ch] = bot_sum[FRAC_BITS +: CHAN_WIDTH];
      end
   end

   logic                   s2_inb_ff;
   logic [FRAC_BITS-1:0]   s2_fy_ff;
   argb_type               s2_top_ff, s2_bot_ff;
   logic [PIXEL_WIDTH-1:0] s2_dest_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_inb_ff  <= s1_inb_ff;
         s2_fy_ff   <= s1_fy_ff;
         s2_top_ff  <= s2_top_in;
         s2_bot_ff  <= s2_bot_in;
         s2_dest_ff <= s1_dest_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: vertical lerp
   // ---------------------------------------------------------------
   argb_type s3_col_in;
   logic [FRAC_BITS-1:0] iy;
   logic [SUM_WIDTH-1:0] vert_sum;

   always_comb begin
      iy = FRAC_MASK - s2_fy_ff;
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         vert_sum = SUM_WIDTH'(s2_top_ff[ch]) * SUM_WIDTH'(iy)
                  + SUM_WIDTH'(s2_bot_ff[ch]) * SUM_WIDTH'(s2_fy_ff);
         s3_col_in[ch] = vert_sum[FRAC_BITS +: CHAN_WIDTH];
      end
   end

   logic                   s3_inb_ff;
   argb_type               s3_col_ff;
   logic [PIXEL_WIDTH-1:0] s3_dest_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_inb_ff  <= s2_inb_ff;
         s3_col_ff  <= s3_col_in;
         s3_dest_ff <= s2_dest_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: coverage = alpha * tint alpha, color * tint color
   // ---------------------------------------------------------------
   logic [PROD_WIDTH-1:0] cov_prod;
   color_prod_type        s4_ct_in;

   always_comb begin
      cov_prod = PROD_WIDTH'(s3_col_ff[ALPHA_CHAN]) * PROD_WIDTH'(tint_chan[ALPHA_CHAN]);
      for (int ch = 0; ch < NUM_COLORS; ch++) begin
         s4_ct_in[ch] = PROD_WIDTH'(s3_col_ff[ch]) * PROD_WIDTH'(tint_chan[ch]);
      end
   end

   logic                   s4_inb_ff;
   logic [CHAN_WIDTH-1:0]  s4_cov_ff;
   color_prod_type         s4_ct_ff;
   logic [PIXEL_WIDTH-1:0] s4_dest_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_inb_ff  <= s3_inb_ff;
         s4_cov_ff  <= cov_prod[CHAN_WIDTH +: CHAN_WIDTH];
         s4_ct_ff   <= s4_ct_in;
         s4_dest_ff <= s3_dest_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: blend over destination, output register
   // ---------------------------------------------------------------
   argb_type                dest_chan;
   argb_type                blend_pix;
   logic [CHAN_WIDTH-1:0]   inv_cov;
   logic [TRIPLE_WIDTH-1:0] src_term;
   logic [PROD_WIDTH-1:0]   dst_term;
   logic [BLEND_WIDTH-1:0]  blend_sum;
   logic                    s5_written_in;
   logic [PIXEL_WIDTH-1:0]  s5_pixel_in;

   always_comb begin
      dest_chan = s4_dest_ff;
      inv_cov   = CHAN_MAX - s4_cov_ff;
      blend_pix = '0;
      for (int ch = 0; ch < NUM_COLORS; ch++) begin
         src_term  = TRIPLE_WIDTH'(s4_ct_ff[ch]) * TRIPLE_WIDTH'(s4_cov_ff);
         dst_term  = PROD_WIDTH'(dest_chan[ch]) * PROD_WIDTH'(inv_cov);
         blend_sum = BLEND_WIDTH'(src_term[TRIPLE_WIDTH-1:CHAN_WIDTH])
                   + BLEND_WIDTH'(dst_term);
         blend_pix[ch] = blend_sum[CHAN_WIDTH +: CHAN_WIDTH];
      end
      s5_written_in = s4_inb_ff && (s4_cov_ff != '0);
      s5_pixel_in   = s5_written_in ? (blend_pix | or_word_ff) : s4_dest_ff;
   end

   logic [PIXEL_WIDTH-1:0] s5_pixel_ff;
   logic                   s5_written_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_pixel_ff   <= s5_pixel_in;
         s5_written_ff <= s5_written_in;
      end
   end

   assign rsp_pixel_out = s5_pixel_ff;
   assign rsp_written   = s5_written_ff;

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for bilinear_texel_tint_blend_unit. It predicts every result
// beat from the pixel beats and the register settings, and checks the beats in order.
// Depends on btb_pkg and the unit itself.

module tb;
   import btb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 800_000;
   localparam int PHASE_PIXELS  = 119;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 12;
   localparam int FULL_LIM      = (MAX_SOURCE_DIM - 1) << FRAC_BITS;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   // index with no register behind it, writes there are dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 4'd9;

   typedef enum int {ALPHA_OPAQUE, ALPHA_CLEAR, ALPHA_RANDOM, ALPHA_FAINT} alpha_mode_type;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] row;
      logic signed [COORD_WIDTH-1:0] col;
      logic [PIXEL_WIDTH-1:0]        top_left;
      logic [PIXEL_WIDTH-1:0]        top_right;
      logic [PIXEL_WIDTH-1:0]        bottom_right;
      logic [PIXEL_WIDTH-1:0]        bottom_left;
      logic [PIXEL_WIDTH-1:0]        dest;
   } pixel_req_type;

   typedef struct {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   written;
   } blend_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]        csr_index = '0;
   logic [PIXEL_WIDTH-1:0]            csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [COORD_WIDTH-1:0]     req_row_coord = '0;
   logic signed [COORD_WIDTH-1:0]     req_col_coord = '0;
   logic [PIXEL_WIDTH-1:0]            req_texel_top_left = '0;
   logic [PIXEL_WIDTH-1:0]            req_texel_top_right = '0;
   logic [PIXEL_WIDTH-1:0]            req_texel_bottom_right = '0;
   logic [PIXEL_WIDTH-1:0]            req_texel_bottom_left = '0;
   logic [PIXEL_WIDTH-1:0]            req_dest_pixel = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [PIXEL_WIDTH-1:0]            rsp_pixel_out;
   logic                              rsp_written;

   // register copies used by the predictor
   logic [PIXEL_WIDTH-1:0] tint_cfg   = TINT_COLOR_RESET;
   logic [PIXEL_WIDTH-1:0] or_cfg     = ALPHA_OR_WORD_RESET;
   logic [DIM_WIDTH-1:0]   height_cfg = SOURCE_DIM_RESET;
   logic [DIM_WIDTH-1:0]   width_cfg  = SOURCE_DIM_RESET;

   pixel_req_type    pixel_feed_q[$];
   blend_result_type blend_expect_q[$];
   pixel_req_type    cur_req;
   pixel_req_type    next_req;
   blend_result_type oldest_blend;

   bit gapless         = 1'b0;
   int long_hold_asks  = 0;
   int long_hold_seen  = 0;
   int send_gap        = 0;
   int hold_left       = 0;
   int ready_gap       = 0;
   int cycle_count     = 0;
   int error_count     = 0;
   int accepted_count  = 0;
   int result_count    = 0;
   int written_count   = 0;
   int setting_count   = 1;

   bilinear_texel_tint_blend_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_row_coord          (req_row_coord),
      .req_col_coord          (req_col_coord),
      .req_texel_top_left     (req_texel_top_left),
      .req_texel_top_right    (req_texel_top_right),
      .req_texel_bottom_right (req_texel_bottom_right),
      .req_texel_bottom_left  (req_texel_bottom_left),
      .req_dest_pixel         (req_dest_pixel),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_pixel_out          (rsp_pixel_out),
      .rsp_written            (rsp_written)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- prediction ----------------

   // zero reads as one texel, oversize saturates
   function automatic int usable_dim(input logic [DIM_WIDTH-1:0] d);
      if (d == '0) return 1;
      if (int'(d) > MAX_SOURCE_DIM) return MAX_SOURCE_DIM;
      return int'(d);
   endfunction

   // two-pass lerp of one byte lane: horizontal on both rows, then vertical
   function automatic logic [31:0] bilerp_channel(input pixel_req_type p, input int ch,
                                                  input logic [FRAC_BITS-1:0] fx,
                                                  input logic [FRAC_BITS-1:0] fy);
      logic [31:0] ix, iy, fxw, fyw, tl, tr, br, bl, top, bot;
      fxw = 32'(fx);
      fyw = 32'(fy);
      ix  = 32'(FRAC_MASK) - fxw;
      iy  = 32'(FRAC_MASK) - fyw;
      tl  = 32'(p.top_left[ch*CHAN_WIDTH +: CHAN_WIDTH]);
      tr  = 32'(p.top_right[ch*CHAN_WIDTH +: CHAN_WIDTH]);
      br  = 32'(p.bottom_right[ch*CHAN_WIDTH +: CHAN_WIDTH]);
      bl  = 32'(p.bottom_left[ch*CHAN_WIDTH +: CHAN_WIDTH]);
      top = (tl * ix + tr * fxw) >> FRAC_BITS;
      bot = (bl * ix + br * fxw) >> FRAC_BITS;
      return (top * iy + bot * fyw) >> FRAC_BITS;
   endfunction

   function automatic blend_result_type blend_pixel(input pixel_req_type p);
      longint row_l, col_l, row_lim, col_lim;
      logic [FRAC_BITS-1:0] fx, fy;
      logic [31:0] a, c, t, d, v, amax;
      logic [PIXEL_WIDTH-1:0] pix;
      blend_result_type res;
      row_l   = longint'(p.row);
      col_l   = longint'(p.col);
      row_lim = longint'(usable_dim(height_cfg) - 1) << FRAC_BITS;
      col_lim = longint'(usable_dim(width_cfg) - 1) << FRAC_BITS;
      amax    = 32'(CHAN_MAX);
      res.pixel   = p.dest;
      res.written = 1'b0;
      if (row_l > 0 && col_l > 0 && row_l < row_lim && col_l < col_lim) begin
         fy = p.row[FRAC_BITS-1:0];
         fx = p.col[FRAC_BITS-1:0];
         a  = (bilerp_channel(p, ALPHA_CHAN, fx, fy) * 32'(tint_cfg[31:24])) >> CHAN_WIDTH;
         if (a > amax) a = amax;
         // zero coverage leaves the destination alone
         if (a != 32'd0) begin
            pix = '0;
            for (int ch = 0; ch < NUM_COLORS; ch++) begin
               c = bilerp_channel(p, ch, fx, fy);
               t = 32'(tint_cfg[ch*CHAN_WIDTH +: CHAN_WIDTH]);
               d = 32'(p.dest[ch*CHAN_WIDTH +: CHAN_WIDTH]);
               v = (((c * a * t) >> CHAN_WIDTH) + d * (amax - a)) >> CHAN_WIDTH;
               pix[ch*CHAN_WIDTH +: CHAN_WIDTH] = v[CHAN_WIDTH-1:0];
            end
            res.pixel   = pix | or_cfg;
            res.written = 1'b1;
         end
      end
      return res;
   endfunction

   // ---------------- stimulus helpers ----------------

   // mostly back-to-back, some short gaps, rare long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // mostly strictly inside the texture, the rest edges and junk
   function automatic logic signed [COORD_WIDTH-1:0] coord_pick(input int lim);
      int r;
      logic signed [COORD_WIDTH-1:0] v;
      r = $urandom_range(99, 0);
      if (r < 80 && lim > 1) begin
         v = COORD_WIDTH'($urandom_range(lim - 1, 1));
         if (r < 8) v[FRAC_BITS-1:0] = '0;
         else if (r < 16) v[FRAC_BITS-1:0] = FRAC_MASK;
      end else begin
         case ($urandom_range(7, 0))
            0:       v = '0;
            1:       v = COORD_WIDTH'(lim);
            2:       v = COORD_WIDTH'(lim - 1);
            3:       v = COORD_WIDTH'(lim + 1);
            4:       v = '1;
            5:       v = COORD_MIN;
            6:       v = COORD_MAX;
            default: v = COORD_WIDTH'($urandom);
         endcase
      end
      return v;
   endfunction

   function automatic logic [PIXEL_WIDTH-1:0] texel_pick(input alpha_mode_type mode);
      logic [PIXEL_WIDTH-1:0] t;
      t = $urandom;
      case (mode)
         ALPHA_OPAQUE: t[31:24] = CHAN_MAX;
         ALPHA_CLEAR:  t[31:24] = '0;
         ALPHA_FAINT:  t[31:24] = CHAN_WIDTH'($urandom_range(3, 0));
         default:      ;
      endcase
      return t;
   endfunction

   function automatic pixel_req_type rand_pixel();
      pixel_req_type p;
      alpha_mode_type mode;
      case ($urandom_range(5, 0))
         0:       mode = ALPHA_OPAQUE;
         1:       mode = ALPHA_CLEAR;
         5:       mode = ALPHA_FAINT;
         default: mode = ALPHA_RANDOM;
      endcase
      p.row          = coord_pick((usable_dim(height_cfg) - 1) << FRAC_BITS);
      p.col          = coord_pick((usable_dim(width_cfg) - 1) << FRAC_BITS);
      p.top_left     = texel_pick(mode);
      p.top_right    = texel_pick(mode);
      p.bottom_right = texel_pick(mode);
      p.bottom_left  = texel_pick(mode);
      p.dest         = $urandom;
      return p;
   endfunction

   // dimension setting for the random phases, small ones favored
   function automatic logic [DIM_WIDTH-1:0] dim_pick();
      int r;
      r = $urandom_range(99, 0);
      if (r < 70) return DIM_WIDTH'($urandom_range(16, 2));
      if (r < 90) return DIM_WIDTH'($urandom_range(MAX_SOURCE_DIM, 1));
      return DIM_WIDTH'($urandom_range(4095, 0));
   endfunction

   // dimension word, sometimes with junk above the register width
   function automatic logic [PIXEL_WIDTH-1:0] dim_word(input logic [DIM_WIDTH-1:0] dim);
      logic [PIXEL_WIDTH-1:0] w;
      w = {PIXEL_WIDTH{1'b0}};
      if ($urandom_range(4, 0) == 0) w = $urandom;
      w[DIM_WIDTH-1:0] = dim;
      return w;
   endfunction

   task automatic queue_pixel(input int row, input int col,
                              input logic [PIXEL_WIDTH-1:0] tl, input logic [PIXEL_WIDTH-1:0] tr,
                              input logic [PIXEL_WIDTH-1:0] br, input logic [PIXEL_WIDTH-1:0] bl,
                              input logic [PIXEL_WIDTH-1:0] dest);
      pixel_req_type p;
      p.row = COORD_WIDTH'(row); p.col = COORD_WIDTH'(col);
      p.top_left = tl; p.top_right = tr; p.bottom_right = br; p.bottom_left = bl;
      p.dest = dest;
      pixel_feed_q.push_back(p);
   endtask

   // one register write beat; the shadow copy follows at the handshake edge
   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [PIXEL_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TINT_COLOR:    tint_cfg   = data;
         CSR_ALPHA_OR_WORD: or_cfg     = data;
         CSR_SOURCE_HEIGHT: height_cfg = data[DIM_WIDTH-1:0];
         CSR_SOURCE_WIDTH:  width_cfg  = data[DIM_WIDTH-1:0];
         default:           ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // settle until every queued beat is sent and every result is back
   task automatic wait_idle();
      @(negedge clock);
      while (pixel_feed_q.size() != 0 || req_valid || blend_expect_q.size() != 0)
         @(negedge clock);
   endtask

   // ---------------- pixel driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            blend_expect_q.push_back(blend_pixel(cur_req));
            accepted_count++;
         end
         // slot is free for a new beat after this edge
         if (!req_valid || req_ready) begin
            if (send_gap > 0 && !gapless) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pixel_feed_q.size() != 0) begin
               next_req = pixel_feed_q.pop_front();
               cur_req                <= next_req;
               req_row_coord          <= next_req.row;
               req_col_coord          <= next_req.col;
               req_texel_top_left     <= next_req.top_left;
               req_texel_top_right    <= next_req.top_right;
               req_texel_bottom_right <= next_req.bottom_right;
               req_texel_bottom_left  <= next_req.bottom_left;
               req_dest_pixel         <= next_req.dest;
               req_valid              <= 1'b1;
               send_gap               <= gapless ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result ready / backpressure ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (long_hold_asks != long_hold_seen) begin
         // long hold-off so the pipe fills and stalls the input
         long_hold_seen <= long_hold_asks;
         hold_left      <= LONG_HOLD;
         rsp_ready      <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (gapless) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_gap = pick_gap();
         rsp_ready <= (ready_gap == 0);
         hold_left <= (ready_gap == 0) ? 0 : ready_gap - 1;
      end
   end

   // ---------------- result monitor ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (blend_expect_q.size() == 0) begin
            error_count++;
            $display("%0t ns: result beat with nothing expected, got pixel %08h written %0b",
                     $time, rsp_pixel_out, rsp_written);
         end else begin
            oldest_blend = blend_expect_q.pop_front();
            if (oldest_blend.written) written_count++;
            if (rsp_pixel_out !== oldest_blend.pixel) begin
               error_count++;
               $display("%0t ns: pixel_out mismatch, expected %08h, actual %08h",
                        $time, oldest_blend.pixel, rsp_pixel_out);
            end
            if (rsp_written !== oldest_blend.written) begin
               error_count++;
               $display("%0t ns: written mismatch, expected %0b, actual %0b",
                        $time, oldest_blend.written, rsp_written);
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------- test sequence ----------------
   initial begin
      logic [PIXEL_WIDTH-1:0] tint_v, or_v;
      logic [DIM_WIDTH-1:0]   h_v, w_v;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed beats at reset settings (2048 x 2048, white tint, no OR word)
      queue_pixel(1, 1, '1, '1, '1, '1, 32'h0000_0000);
      queue_pixel(FULL_LIM - 1, FULL_LIM - 1, '1, '1, '1, '1, 32'h1234_5678);
      queue_pixel(0, 100000, '1, '1, '1, '1, 32'hA5A5_A5A5);
      queue_pixel(100000, 0, '1, '1, '1, '1, 32'h5A5A_5A5A);
      queue_pixel(FULL_LIM, 100000, '1, '1, '1, '1, 32'h0102_0304);
      queue_pixel(100000, FULL_LIM, '1, '1, '1, '1, 32'h0506_0708);
      queue_pixel(-1, 100000, '1, '1, '1, '1, 32'h090A_0B0C);
      queue_pixel(int'(COORD_MIN), int'(COORD_MAX), '1, '1, '1, '1, 32'hDEAD_BEEF);
      queue_pixel(int'(COORD_MAX), int'(COORD_MIN), '1, '1, '1, '1, 32'hCAFE_F00D);
      // integer position, then fraction all ones
      queue_pixel(5 << FRAC_BITS, 7 << FRAC_BITS, 32'hFF10_2030, 32'h8040_5060,
                  32'h4070_8090, 32'hC0A0_B0C0, 32'h0F0F_0F0F);
      queue_pixel((5 << FRAC_BITS) | int'(FRAC_MASK), (7 << FRAC_BITS) | int'(FRAC_MASK),
                  32'hFF10_2030, 32'h8040_5060, 32'h4070_8090, 32'hC0A0_B0C0,
                  32'h0F0F_0F0F);
      // transparent and faint texels give zero coverage
      queue_pixel(300000, 400000, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                  32'h1357_9BDF);
      queue_pixel(300000, 400000, 32'h01FF_FFFF, 32'h01FF_FFFF, 32'h01FF_FFFF, 32'h01FF_FFFF,
                  32'h2468_ACE0);
      // single opaque corner
      queue_pixel(9 << FRAC_BITS, 9 << FRAC_BITS, '1, '0, '0, '0, 32'h7777_7777);
      queue_pixel(9 << FRAC_BITS, 9 << FRAC_BITS, '0, '0, '1, '0, 32'h7777_7777);
      // black over white, white over white, mid fraction
      queue_pixel(200000, 200000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000,
                  '1);
      queue_pixel(200000, 200000, '1, '1, '1, '1, '1);
      queue_pixel((3 << FRAC_BITS) | 32'h2000, (3 << FRAC_BITS) | 32'h2000, '1, 32'h8000_0000,
                  32'h7FFF_FFFF, '0, '0);
      for (int k = 0; k < 4; k++) pixel_feed_q.push_back(rand_pixel());
      wait_idle();

      for (int phase = 1; phase <= 12; phase++) begin
         case (phase)
            1: begin tint_v = '1; or_v = 32'hFF00_0000; h_v = DIM_WIDTH'(MAX_SOURCE_DIM);
                     w_v = DIM_WIDTH'(MAX_SOURCE_DIM); end
            2: begin tint_v = '0; or_v = '1; h_v = DIM_WIDTH'(1); w_v = DIM_WIDTH'(1); end
            3: begin tint_v = $urandom; or_v = $urandom; h_v = '0; w_v = '0; end
            4: begin tint_v = $urandom; or_v = '0; h_v = DIM_WIDTH'(4095);
                     w_v = DIM_WIDTH'(MAX_SOURCE_DIM + 1); end
            5: begin tint_v = 32'hFF00_0000; or_v = '0; h_v = DIM_WIDTH'(2);
                     w_v = DIM_WIDTH'(2); end
            default: begin
               tint_v = $urandom;
               if ($urandom_range(3, 0) == 0) tint_v[31:24] = CHAN_MAX;
               case ($urandom_range(3, 0))
                  0:       or_v = $urandom;
                  1:       or_v = '0;
                  default: or_v = 32'hFF00_0000;
               endcase
               h_v = dim_pick();
               w_v = dim_pick();
            end
         endcase
         csr_write(CSR_TINT_COLOR, tint_v);
         csr_write(CSR_ALPHA_OR_WORD, or_v);
         csr_write(CSR_SOURCE_HEIGHT, dim_word(h_v));
         csr_write(CSR_SOURCE_WIDTH, dim_word(w_v));
         if (phase == 5) csr_write(CSR_SPARE_INDEX, $urandom);
         setting_count++;

         // phase 6: sender floods while the receiver holds off; phase 7: no idling at all
         gapless = (phase == 6 || phase == 7);
         if (phase == 6) long_hold_asks++;
         for (int k = 0; k < PHASE_PIXELS; k++) pixel_feed_q.push_back(rand_pixel());
         wait_idle();
         gapless = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d pixel beats under %0d register settings: %0d blended, %0d passed.",
               accepted_count, setting_count, written_count, result_count - written_count);
      $display("Included edge coordinates, clamped sizes, zero coverage and a %0d-cycle stall.",
               LONG_HOLD);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
